FILE: design/bfa_pkg.sv
// Shared types, constants and helpers for the bitmap first-fit block allocator.
package bfa_pkg;

  localparam int BITMAP_BYTES_DEF = 2048;
  localparam int IDX_W            = 11;
  localparam int VAL_W            = 8;
  localparam int BN_W             = 14;
  localparam int BIT_W            = 3;

  localparam logic [VAL_W-1:0] FULL_BYTE = 8'hFF;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_ALLOC = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] byte_index;
    logic [VAL_W-1:0] byte_value;
  } bfa_in_t;

  typedef struct packed {
    logic [BN_W-1:0] block_number;
    logic            found;
  } bfa_out_t;

  // Lowest clear bit of a byte; 7 when the low seven bits are all set.
  function automatic logic [BIT_W-1:0] lowest_clear_bit(input logic [VAL_W-1:0] v);
    logic [BIT_W-1:0] b;
    b = BIT_W'(VAL_W - 1);
    for (int k = VAL_W - 2; k >= 0; k--) begin
      if (!v[k]) begin
        b = BIT_W'(k);
      end
    end
    return b;
  endfunction

endpackage

FILE: design/bitmap_first_free_block_allocator_top.sv
// First-fit free block allocator over a block-usage bitmap: top level.
//
// The block keeps a bitmap of BITMAP_BYTES bytes in one on-chip memory, one
// bit per disk block, a set bit meaning the block is used. A request with
// kind = load writes one bitmap byte (ignored when byte_index is not below
// BITMAP_BYTES) and gives no result. A request with kind = allocate scans
// bytes 1 upward (byte 0 is never used), marks the lowest clear bit of the
// first byte that is not full, and returns block_number = byte*8+bit (kept
// to 14 bits) with found = 1; when every scanned byte is full it returns 0
// with found = 0 and changes nothing. The scan issues one memory read per
// cycle through the single read port. in_ready is low while a scan runs.
// After reset the block runs a clearing pass, one byte a cycle, with
// in_ready low, so that every block starts free. Results sit in an output
// register, so loads are taken while an earlier result waits to be taken.
module bitmap_first_free_block_allocator_top #(
  parameter int BITMAP_BYTES = bfa_pkg::BITMAP_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bfa_pkg::bfa_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bfa_pkg::bfa_out_t out_data
);
  import bfa_pkg::*;

  localparam int AW     = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
  localparam int WIDE_W = (AW + BIT_W > BN_W) ? AW + BIT_W : BN_W;
  localparam logic [AW-1:0] LAST = AW'(BITMAP_BYTES - 1);

  // Sequencer codes
  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_PUT  = 2'd3;

  logic [1:0]    state_r,     state_nxt;
  logic [AW-1:0] addr_r,      addr_nxt;     // clear pointer, then scan read pointer
  logic [AW-1:0] chk_addr_r,  chk_addr_nxt; // byte whose data is on the read port
  logic          chk_vld_r,   chk_vld_nxt;
  bfa_out_t      res_r,       res_nxt;      // result waiting for the output slot
  logic          out_valid_r, out_valid_nxt;
  bfa_out_t      out_data_r,  out_data_nxt;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [VAL_W-1:0] ram_wdata;
  logic [VAL_W-1:0] ram_rdata;
  logic [BIT_W-1:0] free_bit;
  logic [WIDE_W-1:0] bn_wide;
  logic             in_fire;
  logic             load_hit;

  bfa_ram #(
    .DEPTH (BITMAP_BYTES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign load_hit  = 32'(in_data.byte_index) < 32'(BITMAP_BYTES);
  assign free_bit  = lowest_clear_bit(ram_rdata);
  assign bn_wide   = WIDE_W'({chk_addr_r, free_bit});

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    chk_addr_nxt  = chk_addr_r;
    chk_vld_nxt   = chk_vld_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = addr_r;
    ram_wdata     = '0;

    case (state_r)
      ST_CLR: begin
        // Zero one byte a cycle until the last one is done
        ram_we    = 1'b1;
        ram_waddr = addr_r;
        if (addr_r == LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          if (in_data.kind == KIND_LOAD) begin
            ram_we    = load_hit;
            ram_waddr = AW'(in_data.byte_index);
            ram_wdata = in_data.byte_value;
          end else begin
            // Start the scan at byte 1; byte 0 is reserved
            addr_nxt    = AW'(1);
            chk_vld_nxt = 1'b0;
            state_nxt   = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Issue the next read while checking the byte read last cycle
        chk_addr_nxt = addr_r;
        chk_vld_nxt  = 1'b1;
        if (addr_r != LAST) begin
          addr_nxt = addr_r + 1'b1;
        end
        if (chk_vld_r) begin
          if (ram_rdata != FULL_BYTE) begin
            ram_we               = 1'b1;
            ram_waddr            = chk_addr_r;
            ram_wdata            = ram_rdata | (VAL_W'(1) << free_bit);
            res_nxt.block_number = bn_wide[BN_W-1:0];
            res_nxt.found        = 1'b1;
            state_nxt            = ST_PUT;
          end else if (chk_addr_r == LAST) begin
            res_nxt.block_number = '0;
            res_nxt.found        = 1'b0;
            state_nxt            = ST_PUT;
          end
        end
      end

      ST_PUT: begin
        // Hold until the output slot is free, then hand the result over
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      addr_r      <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_addr_r <= chk_addr_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: design/bfa_ram.sv
// Single-port-write, registered-read byte memory that holds the usage bitmap.
module bfa_ram #(
  parameter int DEPTH = bfa_pkg::BITMAP_BYTES_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [bfa_pkg::VAL_W-1:0] wdata,
  input  logic [AW-1:0]            raddr,
  output logic [bfa_pkg::VAL_W-1:0] rdata
);
  import bfa_pkg::*;

  logic [VAL_W-1:0] mem_r [DEPTH];
  logic [VAL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: tb/sv/tb_bitmap_first_free_block_allocator_top.sv
// Self-checking testbench for the bitmap first-fit block allocator.
import bfa_pkg::*;

class block_usage_mirror;
  logic [VAL_W-1:0] usage [BITMAP_BYTES_DEF];
  bfa_out_t         grants_due [$];
  int               mismatches;
  int               grants_seen;

  function new();
    foreach (usage[i]) usage[i] = '0;
    mismatches  = 0;
    grants_seen = 0;
  endfunction

  function int unsigned lowest_free_bit(logic [VAL_W-1:0] v);
    int unsigned pos;
    pos = 0;
    for (int k = VAL_W - 1; k >= 0; k--) begin
      if (!v[k]) pos = k;
    end
    return pos;
  endfunction

  // Update the shadow bitmap and queue the grant that an allocate produces.
  function void note_request(bfa_in_t req);
    bfa_out_t    grant;
    int unsigned pos;
    if (req.kind == KIND_LOAD) begin
      if (int'(req.byte_index) < BITMAP_BYTES_DEF) usage[req.byte_index] = req.byte_value;
      return;
    end
    grant = '0;
    for (int i = 1; i < BITMAP_BYTES_DEF; i++) begin
      if (usage[i] != FULL_BYTE) begin
        pos = lowest_free_bit(usage[i]);
        usage[i][pos] = 1'b1;
        grant.block_number = BN_W'(i * 8 + pos);
        grant.found = 1'b1;
        break;
      end
    end
    grants_due.push_back(grant);
  endfunction

  function void check_grant(bfa_out_t got);
    bfa_out_t want;
    grants_seen++;
    if (grants_due.size() == 0) begin
      $display("%0t: unexpected grant block_number=%0d found=%0b",
               $time, got.block_number, got.found);
      mismatches++;
      return;
    end
    want = grants_due.pop_front();
    if (got.block_number !== want.block_number) begin
      $display("%0t: block_number mismatch expected=%0d actual=%0d",
               $time, want.block_number, got.block_number);
      mismatches++;
    end
    if (got.found !== want.found) begin
      $display("%0t: found mismatch expected=%0b actual=%0b", $time, want.found, got.found);
      mismatches++;
    end
  endfunction

  function int pending();
    return grants_due.size();
  endfunction
endclass

module tb_bitmap_first_free_block_allocator_top;

  // The limit covers every allocate scanning the whole bitmap, the clearing
  // pass and all stalls.
  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int HOLD_OFF_LEN  = 400;
  localparam int HOLD_OFF_AT   = 30;
  localparam int RANDOM_ITEMS  = 230;
  localparam int TAIL_ITEMS    = 40;
  localparam int LOW_REGION    = 48;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  bfa_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  bfa_out_t out_data;

  // When set, neither side inserts idle cycles.
  logic steady;

  block_usage_mirror mirror;

  bitmap_first_free_block_allocator_top #(
    .BITMAP_BYTES(BITMAP_BYTES_DEF)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Cycle watchdog: end the run if the block hangs.
  initial begin
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic bfa_in_t load_req(int unsigned idx, logic [VAL_W-1:0] val);
    bfa_in_t req;
    req.kind       = KIND_LOAD;
    req.byte_index = IDX_W'(idx);
    req.byte_value = val;
    return req;
  endfunction

  // Allocate requests carry random index and value bits, which the block ignores.
  function automatic bfa_in_t alloc_req();
    bfa_in_t req;
    req.kind       = KIND_ALLOC;
    req.byte_index = IDX_W'($urandom);
    req.byte_value = VAL_W'($urandom);
    return req;
  endfunction

  function automatic logic [VAL_W-1:0] one_hole();
    return FULL_BYTE & ~(VAL_W'(1) << $urandom_range(VAL_W - 1));
  endfunction

  // Offer one request from a falling edge and hold it until accepted; return
  // at the falling edge after acceptance so the next request can follow at once.
  task automatic send_req(bfa_in_t req);
    int unsigned gap;
    gap = 0;
    if (!steady && $urandom_range(99) < 15) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    mirror.note_request(req);
    @(negedge clk);
  endtask

  // Drop valid and hold until every queued grant has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (mirror.pending() != 0) @(negedge clk);
  endtask

  // Mostly plant content near the scan front so allocates interact with it;
  // now and then write anywhere in the bitmap.
  task automatic send_random_req();
    int unsigned pick;
    int unsigned vpick;
    logic [VAL_W-1:0] val;
    pick  = $urandom_range(99);
    vpick = $urandom_range(99);
    if (vpick < 40) val = FULL_BYTE;
    else if (vpick < 60) val = one_hole();
    else if (vpick < 80) val = VAL_W'($urandom);
    else val = '0;
    if (pick < 50) send_req(alloc_req());
    else if (pick < 85) send_req(load_req($urandom_range(LOW_REGION), val));
    else send_req(load_req($urandom_range(BITMAP_BYTES_DEF - 1), VAL_W'($urandom)));
  endtask

  // Result side: sample accepted grants at the rising edge.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) mirror.check_grant(out_data);
    end
  end

  // Result side: drive ready at the falling edge, with one long hold-off
  // while the sender keeps offering, so the output register fills and the
  // input stalls.
  initial begin
    bit held;
    held = 1'b0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && mirror.grants_seen >= HOLD_OFF_AT) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_LEN) @(negedge clk);
      end
      out_ready <= steady || ($urandom_range(99) >= 15);
    end
  end

  initial begin
    mirror   = new();
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    steady   = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: fresh bitmap, byte 0 skipped, full bytes passed over,
    // holes taken lowest first, extremes of every field.
    send_req(alloc_req());
    send_req(alloc_req());
    send_req(load_req(1, FULL_BYTE));
    send_req(alloc_req());
    send_req(load_req(0, 8'h00));
    send_req(alloc_req());
    send_req(load_req(2, 8'hA5));
    send_req(alloc_req());
    send_req(load_req(2, FULL_BYTE));
    send_req(load_req(3, 8'h7F));
    send_req(alloc_req());
    send_req(load_req(BITMAP_BYTES_DEF - 1, 8'h00));
    send_req(load_req(1024, 8'h55));
    send_req('{kind: KIND_ALLOC, byte_index: '1, byte_value: '1});
    send_req('{kind: KIND_ALLOC, byte_index: '0, byte_value: '0});
    send_req(load_req(1, 8'h00));
    send_req(alloc_req());
    send_req(load_req(4, 8'h80));
    send_req(load_req(1, FULL_BYTE));
    send_req(load_req(3, FULL_BYTE));
    send_req(alloc_req());
    send_req(alloc_req());

    // Random body, with a stretch free of idling and a full drain midway.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 100) steady = 1'b1;
      if (n == 170) steady = 1'b0;
      if (n == 190) wait_drained();
      send_random_req();
    end

    // Tail: single holes planted anywhere past byte 0, mixed with allocates.
    for (int n = 0; n < TAIL_ITEMS; n++) begin
      if ($urandom_range(1) == 0) send_req(alloc_req());
      else send_req(load_req($urandom_range(1, BITMAP_BYTES_DEF - 1), one_hole()));
    end

    in_valid <= 1'b0;
    while (mirror.pending() != 0) @(negedge clk);
    // Allow one more full scan so a stray grant would still show up.
    repeat (BITMAP_BYTES_DEF + 16) @(negedge clk);

    if (mirror.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
